### src/assert_macros.svh
// assertion macros shared by the tone generator rtl
// depends on i_clk and i_rst_n being visible in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define GTWG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition must never be seen outside reset
`define GTWG_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

### src/gtwg_pkg.sv
// types, codes and the quarter-wave sine generator for the tone generator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gtwg_pkg;

    localparam int Q32_BITS = 32;
    localparam int Q15_SHIFT = 15;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
    localparam logic [1:0] WAVE_SAWTOOTH = 2'd3;

    localparam logic FMT_U8  = 1'b0;
    localparam logic FMT_S16 = 1'b1;

    localparam logic REG_WAVE_SHAPE    = 1'b0;
    localparam logic REG_SAMPLE_FORMAT = 1'b1;

    localparam logic [1:0] RST_WAVE_SHAPE    = WAVE_SINE;
    localparam logic       RST_SAMPLE_FORMAT = FMT_S16;

    localparam logic signed [16:0] Y_PLUS_ONE  = 17'sd32768;
    localparam logic signed [16:0] Y_MINUS_ONE = -17'sd32768;
    localparam logic [15:0] TRI_QUARTER = 16'd16384;
    localparam logic signed [17:0] TRI_CENTER = 18'sd49152;
    localparam logic [31:0] S16_MAX = 32'd32767;
    localparam logic signed [25:0] U8_GAIN = 26'sd127;
    localparam logic signed [25:0] U8_OFFSET_Q15 = 26'sd4161536;
    localparam logic [15:0] U8_SILENCE = 16'd127;
    localparam logic [15:0] S16_SILENCE = 16'd0;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic        sound_on;
        logic [31:0] tone_step;
        logic [31:0] cycle_step;
        logic [32:0] duty_fraction;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sample_value;
        logic               tone_active;
    } t_out_item;

    typedef struct packed {
        logic        active;
        logic [31:0] phase;
    } t_work;

    // entry k of the quarter-wave table, q15, odd series to theta^11 in q30
    function automatic logic [15:0] sine_entry(input int unsigned k,
                                               input int unsigned tbits);
        logic [63:0] theta;
        logic [63:0] theta2;
        logic [63:0] term;
        logic [63:0] sum;
        theta  = (64'(k) * HALF_PI_Q30) >> tbits;
        theta2 = (theta * theta) >> 30;
        term   = theta;
        sum    = theta;
        term   = ((term * theta2) >> 30) / 64'd6;
        sum    = sum - term;
        term   = ((term * theta2) >> 30) / 64'd20;
        sum    = sum + term;
        term   = ((term * theta2) >> 30) / 64'd42;
        sum    = sum - term;
        term   = ((term * theta2) >> 30) / 64'd72;
        sum    = sum + term;
        term   = ((term * theta2) >> 30) / 64'd110;
        sum    = sum - term;
        sum    = (sum + 64'd16384) >> 15;
        return sum[15:0];
    endfunction

endpackage

`default_nettype wire

### src/gtwg_front.sv
// front part: phase accumulators, duty gating and classification of each request
// depends on gtwg_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gtwg_front #(
    parameter int PHASE_BITS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire gtwg_pkg::t_in_item i_item,
    output gtwg_pkg::t_work        o_work
);

    localparam int EXT_BITS = (PHASE_BITS > gtwg_pkg::Q32_BITS) ? PHASE_BITS
                                                                 : gtwg_pkg::Q32_BITS;

    logic [PHASE_BITS-1:0] r_beep_phase, n_beep_phase;
    logic [PHASE_BITS-1:0] r_tone_phase, n_tone_phase;

    logic [EXT_BITS-1:0] tstep_ext, cstep_ext, beep_ext, tone_ext;
    logic [PHASE_BITS-1:0] tstep, cstep;
    logic [31:0] beep_q32, tone_q32;
    logic active;

    assign tstep_ext = EXT_BITS'(i_item.tone_step) << (EXT_BITS - gtwg_pkg::Q32_BITS);
    assign cstep_ext = EXT_BITS'(i_item.cycle_step) << (EXT_BITS - gtwg_pkg::Q32_BITS);
    assign tstep = tstep_ext[EXT_BITS-1 -: PHASE_BITS];
    assign cstep = cstep_ext[EXT_BITS-1 -: PHASE_BITS];

    assign beep_ext = EXT_BITS'(r_beep_phase) << (EXT_BITS - PHASE_BITS);
    assign tone_ext = EXT_BITS'(r_tone_phase) << (EXT_BITS - PHASE_BITS);
    assign beep_q32 = beep_ext[EXT_BITS-1 -: gtwg_pkg::Q32_BITS];
    assign tone_q32 = tone_ext[EXT_BITS-1 -: gtwg_pkg::Q32_BITS];

    assign active = i_item.sound_on && ({1'b0, beep_q32} < i_item.duty_fraction);

    assign o_work.active = active;
    assign o_work.phase  = tone_q32;

    always_comb begin
        n_beep_phase = r_beep_phase;
        n_tone_phase = r_tone_phase;
        if (i_accept) begin
            if (!i_item.sound_on) begin
                n_beep_phase = '0;
                n_tone_phase = '0;
            end else begin
                n_beep_phase = r_beep_phase + cstep;
                n_tone_phase = active ? r_tone_phase + tstep : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beep_phase <= '0;
            r_tone_phase <= '0;
        end else begin
            r_beep_phase <= n_beep_phase;
            r_tone_phase <= n_tone_phase;
        end
    end

    `GTWG_ASSERT(a_sound_off_clears, i_accept && !i_item.sound_on |=> r_beep_phase == '0 && r_tone_phase == '0, "sound off did not clear phases")
    `GTWG_ASSERT(a_gate_clears_tone, i_accept && !active |=> r_tone_phase == '0, "gated request left tone phase")

endmodule

`default_nettype wire

### src/gtwg_queue.sv
// two-entry queue between the front and back parts
// depends on gtwg_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gtwg_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire gtwg_pkg::t_work i_work,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_pop,
    output gtwg_pkg::t_work     o_work
);

    localparam int PTR_BITS = $clog2(gtwg_pkg::QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(gtwg_pkg::QUEUE_DEPTH + 1);

    gtwg_pkg::t_work r_mem [gtwg_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wptr, r_rptr;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic do_push, do_pop;

    assign o_full  = (r_count == CNT_BITS'(gtwg_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_work  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_BITS'(gtwg_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_BITS'(gtwg_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_work;
        end
    end

    `GTWG_NEVER(a_ptr_count, (r_count == '0 || o_full) && r_wptr != r_rptr, "queue pointers disagree with count")

endmodule

`default_nettype wire

### src/gtwg_back.sv
// back part: waveform shaping, sine table read and sample formatting
// depends on gtwg_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gtwg_back #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [1:0]      i_wave_shape,
    input  wire logic            i_sample_format,
    input  wire logic            i_q_valid,
    input  wire gtwg_pkg::t_work i_q_work,
    output logic                 o_q_pop,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output gtwg_pkg::t_out_item  o_result
);

    localparam int SINE_STEPS = 2 ** SINE_TABLE_BITS;
    localparam int K_BITS = SINE_TABLE_BITS + 1;

    logic [15:0] sine_rom [SINE_STEPS+1];

    for (genvar g = 0; g <= SINE_STEPS; g++) begin : g_rom
        assign sine_rom[g] = gtwg_pkg::sine_entry(g, SINE_TABLE_BITS);
    end

    // stage a inputs
    logic [31:0] x;
    logic [15:0] x16;
    logic [1:0] quad;
    logic [K_BITS-1:0] k_raw, k_idx;
    logic signed [17:0] tri_d, tri_abs;
    logic signed [18:0] tri_y;
    logic signed [16:0] other_y;
    logic adv_a, adv_b;

    // stage a registers
    logic r_a_valid;
    logic r_a_active;
    logic r_a_neg;
    logic r_a_is_sine;
    logic [15:0] r_a_sine;
    logic signed [16:0] r_a_y;

    // stage b logic
    logic signed [16:0] y_b;
    logic [16:0] mag;
    logic [31:0] prod;
    logic [15:0] q_s16;
    logic signed [25:0] u8_sum;
    logic [15:0] sample;

    logic r_out_valid;
    gtwg_pkg::t_out_item r_out;

    assign adv_b   = !r_out_valid || i_pop;
    assign adv_a   = !r_a_valid || adv_b;
    assign o_q_pop = adv_a && i_q_valid;

    assign x     = i_q_work.phase;
    assign x16   = x[31:16];
    assign quad  = x[31:30];
    assign k_raw = K_BITS'(x[29 -: SINE_TABLE_BITS]);
    assign k_idx = quad[0] ? K_BITS'(SINE_STEPS) - k_raw : k_raw;

    assign tri_d   = $signed({2'b00, x16}) - gtwg_pkg::TRI_CENTER;
    assign tri_abs = tri_d[17] ? -tri_d : tri_d;
    assign tri_y   = 19'(tri_abs) * 19'sd2 - 19'sd32768;

    always_comb begin
        case (i_wave_shape)
            gtwg_pkg::WAVE_SQUARE: begin
                other_y = x[31] ? gtwg_pkg::Y_MINUS_ONE : gtwg_pkg::Y_PLUS_ONE;
            end
            gtwg_pkg::WAVE_TRIANGLE: begin
                if (x16 < gtwg_pkg::TRI_QUARTER) begin
                    other_y = $signed({x16, 1'b0});
                end else begin
                    other_y = tri_y[16:0];
                end
            end
            gtwg_pkg::WAVE_SAWTOOTH: begin
                other_y = 17'($signed(x16));
            end
            default: begin
                other_y = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv_a) begin
            r_a_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && i_q_valid) begin
            r_a_active  <= i_q_work.active;
            r_a_neg     <= quad[1];
            r_a_is_sine <= (i_wave_shape == gtwg_pkg::WAVE_SINE);
            r_a_sine    <= sine_rom[k_idx];
            r_a_y       <= other_y;
        end
    end

    always_comb begin
        if (r_a_is_sine) begin
            y_b = r_a_neg ? -$signed({1'b0, r_a_sine}) : $signed({1'b0, r_a_sine});
        end else begin
            y_b = r_a_y;
        end
    end

    assign mag    = y_b[16] ? 17'(-y_b) : 17'(y_b);
    assign prod   = 32'(mag) * gtwg_pkg::S16_MAX;
    assign q_s16  = prod[30:15];
    assign u8_sum = 26'(y_b) * gtwg_pkg::U8_GAIN + gtwg_pkg::U8_OFFSET_Q15;

    always_comb begin
        if (i_sample_format == gtwg_pkg::FMT_S16) begin
            if (!r_a_active) begin
                sample = gtwg_pkg::S16_SILENCE;
            end else begin
                sample = y_b[16] ? -q_s16 : q_s16;
            end
        end else begin
            if (!r_a_active) begin
                sample = gtwg_pkg::U8_SILENCE;
            end else begin
                sample = {8'd0, u8_sum[22:15]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_b) begin
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_b && r_a_valid) begin
            r_out.sample_value <= $signed(sample);
            r_out.tone_active  <= r_a_active;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    `GTWG_ASSERT(a_stage_a_holds, r_a_valid && !adv_b |=> r_a_valid, "stage a dropped a stalled request")

endmodule

`default_nettype wire

### src/gated_tone_waveform_generator.sv
// top level of the gated tone generator: configuration registers and wiring
// depends on gtwg_pkg, gtwg_front, gtwg_queue, gtwg_back
//
//  channel   handshake         payload
//  input     push / full       i_item   (t_in_item)
//  result    empty / pop       o_result (t_out_item)
//  config    i_cfg_we          i_cfg_idx, i_cfg_data
//
// one request per cycle sustained while full stays low; phase add and duty compare in the front
// a taken request passes a queue entry, the table stage and the output register to the ports
// the sine table read is registered in the back, formatting feeds the output register
// reset clears both phases, the queue and the back valids; config returns to sine, s16
// a missing pop stalls the output register, then the table stage, then the queue; full rises
// once both queue entries are taken
`timescale 1ns / 1ps
`default_nettype none

module gated_tone_waveform_generator #(
    parameter int PHASE_BITS = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire gtwg_pkg::t_in_item  i_item,
    output logic                     empty,
    input  wire logic                pop,
    output gtwg_pkg::t_out_item      o_result,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_idx,
    input  wire logic [1:0]          i_cfg_data
);

    logic [1:0] r_wave_shape;
    logic r_sample_format;
    logic accept;
    logic q_valid, q_pop;
    gtwg_pkg::t_work front_work, q_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_shape    <= gtwg_pkg::RST_WAVE_SHAPE;
            r_sample_format <= gtwg_pkg::RST_SAMPLE_FORMAT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gtwg_pkg::REG_WAVE_SHAPE: begin
                    r_wave_shape <= i_cfg_data;
                end
                gtwg_pkg::REG_SAMPLE_FORMAT: begin
                    r_sample_format <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign accept = push && !full;

    gtwg_front #(
        .PHASE_BITS(PHASE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_work   (front_work)
    );

    gtwg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_work  (front_work),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_work  (q_work)
    );

    gtwg_back #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wave_shape    (r_wave_shape),
        .i_sample_format (r_sample_format),
        .i_q_valid       (q_valid),
        .i_q_work        (q_work),
        .o_q_pop         (q_pop),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_result        (o_result)
    );

endmodule

`default_nettype wire
